### hw/rtl/tequ_pkg.sv
`timescale 1ns / 1ps
package tequ_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int K_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_KILL = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [2:0] KIND_ACCEPTED = 3'd0;
  localparam logic [2:0] KIND_REJECTED = 3'd1;
  localparam logic [2:0] KIND_EXECUTED = 3'd2;
  localparam logic [2:0] KIND_ABORTED  = 3'd3;
  localparam logic [2:0] KIND_KILLED   = 3'd4;

  typedef struct packed {
    logic [63:0] due;
    logic [63:0] added;
    logic [15:0] id;
    logic        deletable;
    logic        mark;
  } slot_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] id;
    logic [63:0] due;
    logic [63:0] added;
    logic [63:0] cur;
    logic        kept;
  } res_t;

  // Physical slot of a logical position in the circular store.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, head} + {1'b0, pos};
    if (sum >= (CNT_W + 1)'(CAPACITY)) sum = sum - (CNT_W + 1)'(CAPACITY);
    return sum[ADDR_W-1:0];
  endfunction

endpackage

### hw/rtl/tequ_if.sv
`timescale 1ns / 1ps
interface tequ_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] time_value;
  logic        relative;
  logic [15:0] event_id;
  logic        record_add_time;
  logic        deletable;
  logic        force_req;

  modport source (output valid, opcode, time_value, relative, event_id, record_add_time,
                  deletable, force_req, input ready);
  modport sink (input valid, opcode, time_value, relative, event_id, record_add_time,
                deletable, force_req, output ready);
endinterface

interface tequ_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] event_id_res;
  logic [63:0] due_time;
  logic [63:0] added_at;
  logic [63:0] current_time;
  logic        kept;
  logic        last;

  modport source (output valid, kind, event_id_res, due_time, added_at, current_time, kept,
                  last, input ready);
  modport sink (input valid, kind, event_id_res, due_time, added_at, current_time, kept,
                last, output ready);
endinterface

### hw/rtl/tequ_slot_ram.sv
`timescale 1ns / 1ps
module tequ_slot_ram #(
  parameter int Depth = 16,
  parameter int Width = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/timed_event_queue_unit.sv
`timescale 1ns / 1ps
// Timed event queue: keeps up to CAPACITY events sorted by due time in a circular
// single-port-read RAM, with a 64-bit running time. Every stored slot touched takes
// a registered RAM read, then compare and write; adds and ticks do their compares
// through one shared 64-bit comparator. An add is rejected when the store is full,
// else it shifts later events up one slot each until it finds its place and writes
// there. A tick releases due events from the front until one is not yet due, the
// store runs empty or MAX_RESULTS events are out; a kill visits every stored event.
// Results pass through a one-beat holding stage and an output register, so a stalled
// sink stalls the unit. in_ch.ready is high only between items.
module timed_event_queue_unit (
  input logic clk,
  input logic rst,
  tequ_in_if.sink    in_ch,
  tequ_out_if.source out_ch
);
  import tequ_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_ADD_CHK = 11'b00000000010,
    S_ADD_RD  = 11'b00000000100,
    S_ADD_CMP = 11'b00000001000,
    S_ADD_WR  = 11'b00000010000,
    S_T_RD    = 11'b00000100000,
    S_T_CMP   = 11'b00001000000,
    S_K_RD    = 11'b00010000000,
    S_K_CMP   = 11'b00100000000,
    S_K_DONE  = 11'b01000000000,
    S_FIN     = 11'b10000000000
  } state_t;

  state_t            state;
  logic [63:0]       now;
  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  wr;
  logic [K_W-1:0]    k;
  slot_t             req;
  logic              force_r;
  res_t              pend;
  logic              pend_valid;
  res_t              out_r;
  logic              out_last;
  logic              out_valid;
  logic              out_load;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  slot_t             ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [$bits(slot_t)-1:0] ram_rbits;
  slot_t             rd;

  logic [63:0] cmp_b;
  logic        cmp_le;
  logic        out_free;
  logic        emit_ok;
  logic        k_full;
  logic        removed;
  logic        k_go;

  tequ_slot_ram #(.Depth(CAPACITY), .Width($bits(slot_t))) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );
  assign rd = slot_t'(ram_rbits);

  // shared comparator: stored due time against the new due time or the running time
  assign cmp_b    = (state == S_ADD_CMP) ? req.due : now;
  assign cmp_le   = rd.due <= cmp_b;
  assign out_free = !out_valid || out_ch.ready;
  assign emit_ok  = !pend_valid || out_free;
  assign k_full   = k == K_W'(MAX_RESULTS);
  assign removed  = force_r || rd.deletable;
  assign k_go     = k_full || emit_ok;

  // move the held beat into the output register
  assign out_load = pend_valid && (((state == S_T_CMP) && cmp_le && emit_ok) ||
                                   ((state == S_K_CMP) && k_go && !k_full) ||
                                   ((state == S_FIN) && out_free));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys_addr(head, idx);
    ram_wdata = rd;
    ram_raddr = phys_addr(head, idx);
    unique case (state)
      S_ADD_RD:  ram_raddr = phys_addr(head, idx - CNT_W'(1));
      S_ADD_CMP: begin
        ram_we = !cmp_le;
      end
      S_ADD_WR: begin
        ram_we    = emit_ok;
        ram_wdata = req;
      end
      S_K_CMP: begin
        ram_waddr = phys_addr(head, wr);
        ram_we    = k_go && (k_full || !removed);
        if (!k_full) ram_wdata.mark = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ch.ready         = state == S_IDLE;
  assign out_ch.valid        = out_valid;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.event_id_res = out_r.id;
  assign out_ch.due_time     = out_r.due;
  assign out_ch.added_at     = out_r.added;
  assign out_ch.current_time = out_r.cur;
  assign out_ch.kept         = out_r.kept;
  assign out_ch.last         = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r    <= pend;
      out_last <= state == S_FIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now        <= '0;
      head       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          wr  <= '0;
          k   <= '0;
          force_r       <= in_ch.force_req;
          req.id        <= in_ch.event_id;
          req.deletable <= in_ch.deletable;
          req.mark      <= 1'b0;
          req.due       <= in_ch.relative ? now + in_ch.time_value : in_ch.time_value;
          req.added     <= in_ch.record_add_time ? now : 64'd0;
          if (in_ch.valid) begin
            case (in_ch.opcode)
              OP_TICK: begin
                now   <= now + in_ch.time_value;
                state <= S_T_RD;
              end
              OP_ADD:  state <= S_ADD_CHK;
              OP_KILL: state <= S_K_RD;
              default: ;
            endcase
          end
        end
        S_ADD_CHK: begin
          pend <= '{KIND_REJECTED, req.id, req.due, req.added, now, 1'b0};
          if (count == CNT_W'(CAPACITY)) begin
            pend_valid <= 1'b1;
            state      <= S_FIN;
          end else begin
            idx   <= count;
            state <= S_ADD_RD;
          end
        end
        S_ADD_RD: state <= (idx == '0) ? S_ADD_WR : S_ADD_CMP;
        S_ADD_CMP: begin
          // shift a later event up one slot, or stop at its place
          if (!cmp_le) begin
            idx   <= idx - CNT_W'(1);
            state <= S_ADD_RD;
          end else begin
            state <= S_ADD_WR;
          end
        end
        S_ADD_WR: begin
          if (emit_ok) begin
            count      <= count + CNT_W'(1);
            pend       <= '{KIND_ACCEPTED, req.id, req.due, req.added, now, 1'b0};
            pend_valid <= 1'b1;
            state      <= S_FIN;
          end
        end
        S_T_RD: state <= (k_full || count == '0) ? S_FIN : S_T_CMP;
        S_T_CMP: begin
          if (!cmp_le) begin
            state <= S_FIN;
          end else if (emit_ok) begin
            pend       <= '{rd.mark ? KIND_ABORTED : KIND_EXECUTED, rd.id, rd.due, rd.added,
                            now, 1'b0};
            pend_valid <= 1'b1;
            head       <= phys_addr(head, CNT_W'(1));
            count      <= count - CNT_W'(1);
            k          <= k + K_W'(1);
            state      <= S_T_RD;
          end
        end
        S_K_RD: state <= (idx == count) ? S_K_DONE : S_K_CMP;
        S_K_CMP: begin
          if (k_go) begin
            if (!k_full) begin
              pend       <= '{KIND_KILLED, rd.id, rd.due, rd.added, now, !removed};
              pend_valid <= 1'b1;
              k          <= k + K_W'(1);
            end
            // compact the kept events down over the removed ones
            if (k_full || !removed) wr <= wr + CNT_W'(1);
            idx   <= idx + CNT_W'(1);
            state <= S_K_RD;
          end
        end
        S_K_DONE: begin
          count <= wr;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hw/rtl/tequ_checker.sv
`timescale 1ns / 1ps
module tequ_props (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic       out_kept,
  input logic       out_last
);
  import tequ_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_opcode == OP_TICK || in_opcode == OP_ADD ||
                             in_opcode == OP_KILL) |=> !in_ready)
    else $error("ready high right after accepting work");

  a_add_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_ACCEPTED || out_kind == KIND_REJECTED) |-> out_last)
    else $error("add result not marked last");

  a_kept_kill_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kept |-> out_kind == KIND_KILLED)
    else $error("kept set outside a kill");
endmodule

bind timed_event_queue_unit tequ_props u_tequ_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_kept  (out_ch.kept),
  .out_last  (out_ch.last)
);
